@@ rtl/tcsl_pkg.sv @@
package tcsl_pkg;

	// Field widths fixed by the item format.
	localparam int unsigned IDX_W = 8;
	localparam int unsigned KEY_W = 8;
	localparam int unsigned VAL_W = 32;

	// Node indexes are eight bits wide, so the table never holds more entries than this.
	localparam int unsigned TABLE_MAX = 256;

	// Default node count of the trie.
	localparam int unsigned NODES_DEF = 256;

	// Depth of the queue between the front and the back part.
	localparam int unsigned Q_DEPTH = 2;
	localparam int unsigned Q_AW = 1;

	// Item kinds on the input channel.
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_STEP = 1'b1;

	// One stored trie node.
	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] sibling;
		logic [IDX_W-1:0] child;
		logic [VAL_W-1:0] payload;
	} node_t;

	// What the back part must do with a queued item.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_WALK,
		OP_ZERO
	} item_op_t;

	// One classified item as it waits in the queue.
	typedef struct packed {
		item_op_t op;
		logic [IDX_W-1:0] node_index;
		node_t entry;
	} item_t;

	// States of the walk sequencer.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_CHILD,
		BK_SIB,
		BK_EMIT
	} back_state_t;

	// A node index names a real node when it is nonzero and below the node count.
	function automatic logic node_ok(logic [IDX_W-1:0] idx, int unsigned nodes);
		logic [31:0] wide;
		wide = {{(32-IDX_W){1'b0}}, idx};
		return (idx != '0) && (wide < nodes);
	endfunction

	// Number of table entries that storage needs for a given node count.
	function automatic int unsigned table_depth(int unsigned nodes);
		return (nodes < TABLE_MAX) ? nodes : TABLE_MAX;
	endfunction

endpackage

@@ rtl/tcsl_ram.sv @@
module tcsl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/tcsl_front.sv @@
module tcsl_front #(
	parameter int unsigned NODES = tcsl_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [tcsl_pkg::IDX_W-1:0]        node_index,
	input  logic signed [tcsl_pkg::KEY_W-1:0] key_char,
	input  logic [tcsl_pkg::IDX_W-1:0]        sibling_link,
	input  logic [tcsl_pkg::IDX_W-1:0]        child_link,
	input  logic [tcsl_pkg::VAL_W-1:0]        payload_value,
	output logic                              q_valid,
	output tcsl_pkg::item_t                   q_item,
	input  logic                              q_pop
);

	tcsl_pkg::item_t item_d;
	logic drop;
	logic push;
	logic [31:0] idx_wide;

	tcsl_pkg::item_t slot_q [tcsl_pkg::Q_DEPTH];
	logic [tcsl_pkg::Q_AW-1:0] wr_ptr_q;
	logic [tcsl_pkg::Q_AW-1:0] rd_ptr_q;
	logic [tcsl_pkg::Q_AW:0] count_q;

	assign idx_wide = {{(32-tcsl_pkg::IDX_W){1'b0}}, node_index};

	// Classify the incoming item. Loads beyond the table are dropped here, and steps
	// from a node that does not exist turn into a plain zero result.
	always_comb begin
		item_d.node_index    = node_index;
		item_d.entry.key     = key_char;
		item_d.entry.sibling = sibling_link;
		item_d.entry.child   = child_link;
		item_d.entry.payload = payload_value;
		drop                 = 1'b0;
		if (kind == tcsl_pkg::KIND_LOAD) begin
			item_d.op = tcsl_pkg::OP_LOAD;
			drop      = !(idx_wide < NODES);
		end else if (tcsl_pkg::node_ok(node_index, NODES)) begin
			item_d.op = tcsl_pkg::OP_WALK;
		end else begin
			item_d.op = tcsl_pkg::OP_ZERO;
		end
	end

	assign in_stall = (count_q == (tcsl_pkg::Q_AW+1)'(tcsl_pkg::Q_DEPTH));
	assign push     = in_valid && !in_stall && !drop;
	assign q_valid  = (count_q != '0);
	assign q_item   = slot_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_d;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/tcsl_back.sv @@
module tcsl_back #(
	parameter int unsigned NODES = tcsl_pkg::NODES_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  q_valid,
	input  tcsl_pkg::item_t                                       q_item,
	output logic                                                  q_pop,
	output logic                                                  ram_we,
	output logic [$clog2(tcsl_pkg::table_depth(NODES))-1:0]       ram_waddr,
	output tcsl_pkg::node_t                                       ram_wdata,
	output logic                                                  ram_re,
	output logic [$clog2(tcsl_pkg::table_depth(NODES))-1:0]       ram_raddr,
	input  tcsl_pkg::node_t                                       ram_rdata,
	output logic                                                  out_valid,
	input  logic                                                  out_stall,
	output logic [tcsl_pkg::IDX_W-1:0]                            next_node,
	output logic [tcsl_pkg::VAL_W-1:0]                            match_value
);

	localparam int unsigned AW = $clog2(tcsl_pkg::table_depth(NODES));
	localparam int unsigned VW = $clog2(NODES + 1);
	localparam logic [VW-1:0] HOP_LIMIT = VW'(NODES);

	tcsl_pkg::back_state_t state_q;
	tcsl_pkg::back_state_t state_d;

	logic signed [tcsl_pkg::KEY_W-1:0] ch_q;
	logic [tcsl_pkg::IDX_W-1:0] cur_q;
	logic [VW-1:0] visited_q;
	logic [tcsl_pkg::IDX_W-1:0] res_node_q;
	logic [tcsl_pkg::VAL_W-1:0] res_val_q;
	logic out_valid_q;
	logic [tcsl_pkg::IDX_W-1:0] out_node_q;
	logic [tcsl_pkg::VAL_W-1:0] out_val_q;

	logic [tcsl_pkg::IDX_W-1:0] link;
	logic hop_ok;
	logic key_eq;
	logic key_gt;
	logic out_free;
	logic start_walk;
	logic hop;
	logic res_we;
	logic [tcsl_pkg::IDX_W-1:0] res_node_d;
	logic [tcsl_pkg::VAL_W-1:0] res_val_d;

	// The link to follow next and whether following it is still allowed.
	assign link   = (state_q == tcsl_pkg::BK_CHILD) ? ram_rdata.child : ram_rdata.sibling;
	assign hop_ok = tcsl_pkg::node_ok(link, NODES) && (visited_q < HOP_LIMIT);
	assign key_eq = (ram_rdata.key == ch_q);
	assign key_gt = (ram_rdata.key > ch_q);
	assign out_free = !out_valid_q || !out_stall;

	// Next state of the walk sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcsl_pkg::BK_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						tcsl_pkg::OP_WALK: state_d = tcsl_pkg::BK_CHILD;
						tcsl_pkg::OP_ZERO: state_d = tcsl_pkg::BK_EMIT;
						default:           state_d = tcsl_pkg::BK_IDLE;
					endcase
				end
			end
			tcsl_pkg::BK_CHILD: begin
				state_d = hop_ok ? tcsl_pkg::BK_SIB : tcsl_pkg::BK_EMIT;
			end
			tcsl_pkg::BK_SIB: begin
				priority if (key_eq || key_gt) begin
					state_d = tcsl_pkg::BK_EMIT;
				end else begin
					state_d = hop_ok ? tcsl_pkg::BK_SIB : tcsl_pkg::BK_EMIT;
				end
			end
			tcsl_pkg::BK_EMIT: begin
				if (out_free) begin
					state_d = tcsl_pkg::BK_IDLE;
				end
			end
			default: state_d = tcsl_pkg::BK_IDLE;
		endcase
	end

	// Queue pops, table accesses and result capture for each state.
	always_comb begin
		q_pop      = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_raddr  = link[AW-1:0];
		start_walk = 1'b0;
		hop        = 1'b0;
		res_we     = 1'b0;
		res_node_d = '0;
		res_val_d  = '0;
		unique case (state_q)
			tcsl_pkg::BK_IDLE: begin
				q_pop = q_valid;
				if (q_valid) begin
					unique case (q_item.op)
						tcsl_pkg::OP_LOAD: ram_we = 1'b1;
						tcsl_pkg::OP_WALK: begin
							ram_re     = 1'b1;
							ram_raddr  = q_item.node_index[AW-1:0];
							start_walk = 1'b1;
						end
						default: res_we = 1'b1;
					endcase
				end
			end
			tcsl_pkg::BK_CHILD: begin
				if (hop_ok) begin
					ram_re = 1'b1;
					hop    = 1'b1;
				end else begin
					res_we = 1'b1;
				end
			end
			tcsl_pkg::BK_SIB: begin
				priority if (key_eq) begin
					res_we     = 1'b1;
					res_node_d = cur_q;
					res_val_d  = ram_rdata.payload;
				end else if (key_gt) begin
					res_we = 1'b1;
				end else if (hop_ok) begin
					ram_re = 1'b1;
					hop    = 1'b1;
				end else begin
					res_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_waddr = q_item.node_index[AW-1:0];
	assign ram_wdata = q_item.entry;

	// Walk registers and the pending result.
	always_ff @(posedge clk) begin
		if (start_walk) begin
			ch_q <= q_item.entry.key;
		end
		if (hop) begin
			cur_q <= link;
		end
		if (res_we) begin
			res_node_q <= res_node_d;
			res_val_q  <= res_val_d;
		end
		if (state_q == tcsl_pkg::BK_EMIT && out_free) begin
			out_node_q <= res_node_q;
			out_val_q  <= res_val_q;
		end
	end

	// Sequencer state, hop count and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcsl_pkg::BK_IDLE;
			visited_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_walk) begin
				visited_q <= '0;
			end else if (hop) begin
				visited_q <= visited_q + 1'b1;
			end
			if (state_q == tcsl_pkg::BK_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign next_node   = out_node_q;
	assign match_value = out_val_q;

endmodule

@@ rtl/trie_child_step_lookup.sv @@
// Trie step lookup over a node table in first-child / next-sibling form. A load
// item (kind 0) writes one node; a step item (kind 1) gives a node and a signed
// character and returns the matching child with its payload, or zero for both
// when there is none. Sibling lists must be sorted ascending by signed key. A
// transfer on the input side enters a two-entry queue, so the input keeps taking
// items while the walker is busy or a result waits on the output, until the queue
// is full. The walker owns the single table memory and reads one link per cycle.
// Nodes must be loaded before any step reaches them; a walk longer than NODES
// links gives zero.
module trie_child_step_lookup #(
	parameter int unsigned NODES = tcsl_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              kind,
	input  logic [tcsl_pkg::IDX_W-1:0]        node_index,
	input  logic signed [tcsl_pkg::KEY_W-1:0] key_char,
	input  logic [tcsl_pkg::IDX_W-1:0]        sibling_link,
	input  logic [tcsl_pkg::IDX_W-1:0]        child_link,
	input  logic [tcsl_pkg::VAL_W-1:0]        payload_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tcsl_pkg::IDX_W-1:0]        next_node,
	output logic [tcsl_pkg::VAL_W-1:0]        match_value
);

	localparam int unsigned DEPTH = tcsl_pkg::table_depth(NODES);
	localparam int unsigned AW = $clog2(DEPTH);

	logic q_valid;
	logic q_pop;
	tcsl_pkg::item_t q_item;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	tcsl_pkg::node_t ram_wdata;
	logic ram_re;
	logic [AW-1:0] ram_raddr;
	tcsl_pkg::node_t ram_rdata;

	// Input classification and queue.
	tcsl_front #(
		.NODES(NODES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.node_index   (node_index),
		.key_char     (key_char),
		.sibling_link (sibling_link),
		.child_link   (child_link),
		.payload_value(payload_value),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	// Load execution and sibling walk.
	tcsl_back #(
		.NODES(NODES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.next_node  (next_node),
		.match_value(match_value)
	);

	// Node table.
	tcsl_ram #(
		.WIDTH($bits(tcsl_pkg::node_t)),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// A miss always carries a zero payload.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (next_node == '0) |-> (match_value == '0))
		else $error("miss result carries a nonzero payload");

	// The walker never writes and reads the table in the same cycle.
	a_ram_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("table written and read in one cycle");

	// The walker only pops a queue that holds an item.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	// Every table write comes from a queued load as it leaves the queue.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> q_pop && (q_item.op == tcsl_pkg::OP_LOAD))
		else $error("table write without a queued load");

endmodule

@@ test/trie_child_step_lookup_checker.sv @@
`timescale 1ns / 100ps

module trie_child_step_lookup_checker #(
	parameter int unsigned NODES = tcsl_pkg::NODES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              kind,
	input  logic [tcsl_pkg::IDX_W-1:0]        node_index,
	input  logic signed [tcsl_pkg::KEY_W-1:0] key_char,
	input  logic [tcsl_pkg::IDX_W-1:0]        sibling_link,
	input  logic [tcsl_pkg::IDX_W-1:0]        child_link,
	input  logic [tcsl_pkg::VAL_W-1:0]        payload_value,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [tcsl_pkg::IDX_W-1:0]        next_node,
	input  logic [tcsl_pkg::VAL_W-1:0]        match_value,
	output int                                fail_count,
	output int                                pending
);

	// One predicted step outcome.
	typedef struct {
		logic [tcsl_pkg::IDX_W-1:0] node;
		logic [tcsl_pkg::VAL_W-1:0] value;
	} step_outcome_t;

	// Copy of the node table as the block should hold it.
	tcsl_pkg::node_t node_mem [0:tcsl_pkg::TABLE_MAX-1];

	// Step outcomes still owed by the block, oldest first.
	step_outcome_t outcome_q [$];

	int fails = 0;

	// A link names a real node when it is nonzero and below the node count.
	function automatic logic is_real_node(logic [tcsl_pkg::IDX_W-1:0] idx);
		return (idx != '0) && (int'(idx) < NODES);
	endfunction

	// Walk the sorted child list of a node and return the child whose key matches.
	function automatic logic [tcsl_pkg::IDX_W-1:0] find_child(
			logic [tcsl_pkg::IDX_W-1:0] parent, logic signed [tcsl_pkg::KEY_W-1:0] ch);
		logic [tcsl_pkg::IDX_W-1:0] p;
		logic signed [tcsl_pkg::KEY_W-1:0] k;
		int visited;
		if (!is_real_node(parent))
			return '0;
		p = node_mem[parent].child;
		visited = 0;
		while (p != '0) begin
			if (!is_real_node(p))
				return '0;
			if (visited >= NODES)
				return '0;
			visited++;
			k = node_mem[p].key;
			if (k == ch)
				return p;
			// The list is sorted, so a larger key ends the search.
			if (k > ch)
				return '0;
			p = node_mem[p].sibling;
		end
		return '0;
	endfunction

	// Follow both channels, predict each step and compare each result.
	always @(posedge clk) begin
		step_outcome_t got;
		step_outcome_t want;
		logic [tcsl_pkg::IDX_W-1:0] hit;
		if (arst_n) begin
			// Result side: the oldest prediction must match.
			if (out_valid && !out_stall) begin
				got.node = next_node;
				got.value = match_value;
				if (outcome_q.size() == 0) begin
					$error("result transfer with no step waiting: next_node %0d match_value %0h",
						got.node, got.value);
					fails++;
				end else begin
					want = outcome_q.pop_front();
					if (got.node !== want.node) begin
						$error("next_node: expected %0d, actual %0d", want.node, got.node);
						fails++;
					end
					if (got.value !== want.value) begin
						$error("match_value: expected %0h, actual %0h", want.value, got.value);
						fails++;
					end
				end
			end

			// Item side: loads update the table, steps queue a prediction.
			if (in_valid && !in_stall) begin
				if (kind == tcsl_pkg::KIND_LOAD) begin
					if (int'(node_index) < NODES) begin
						node_mem[node_index].key = key_char;
						node_mem[node_index].sibling = sibling_link;
						node_mem[node_index].child = child_link;
						node_mem[node_index].payload = payload_value;
					end
				end else begin
					hit = find_child(node_index, key_char);
					want.node = hit;
					want.value = (hit != '0) ? node_mem[hit].payload : '0;
					outcome_q.push_back(want);
				end
			end
		end
		fail_count <= fails;
		pending <= outcome_q.size();
	end

endmodule

@@ test/trie_child_step_lookup_tb.sv @@
`timescale 1ns / 100ps

module trie_child_step_lookup_tb;

	localparam int LIMIT = 2000000;
	localparam int ITEMS = 700;
	localparam int DRAIN = 32;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic                              kind;
	logic [tcsl_pkg::IDX_W-1:0]        node_index;
	logic signed [tcsl_pkg::KEY_W-1:0] key_char;
	logic [tcsl_pkg::IDX_W-1:0]        sibling_link;
	logic [tcsl_pkg::IDX_W-1:0]        child_link;
	logic [tcsl_pkg::VAL_W-1:0]        payload_value;
	logic                              out_valid;
	logic                              out_stall;
	logic [tcsl_pkg::IDX_W-1:0]        next_node;
	logic [tcsl_pkg::VAL_W-1:0]        match_value;
	int                                fail_count;
	int                                pending;

	// What has been loaded so far, used to aim steps at real children.
	logic signed [tcsl_pkg::KEY_W-1:0] tree_key   [0:tcsl_pkg::TABLE_MAX-1];
	logic [tcsl_pkg::IDX_W-1:0]        tree_sib   [0:tcsl_pkg::TABLE_MAX-1];
	logic [tcsl_pkg::IDX_W-1:0]        tree_child [0:tcsl_pkg::TABLE_MAX-1];

	bit in_calm;
	int cycles = 0;
	int stall_left = 0;

	trie_child_step_lookup #(.NODES(tcsl_pkg::NODES_DEF)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.node_index(node_index),
		.key_char(key_char),
		.sibling_link(sibling_link),
		.child_link(child_link),
		.payload_value(payload_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_node(next_node),
		.match_value(match_value)
	);

	trie_child_step_lookup_checker #(.NODES(tcsl_pkg::NODES_DEF)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.node_index(node_index),
		.key_char(key_char),
		.sibling_link(sibling_link),
		.child_link(child_link),
		.payload_value(payload_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_node(next_node),
		.match_value(match_value),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle count and timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("[trie_child_step_lookup] ERROR");
			$finish;
		end
	end

	// Idle length: mostly none or short, a few long.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Payload words with the extremes showing up now and then.
	function automatic logic [tcsl_pkg::VAL_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Pick a character that lands on or next to one of the node's children.
	function automatic logic signed [tcsl_pkg::KEY_W-1:0] pick_key(
			logic [tcsl_pkg::IDX_W-1:0] parent);
		logic [tcsl_pkg::IDX_W-1:0] p;
		int hops;
		p = tree_child[parent];
		hops = $urandom_range(0, 4);
		while (hops > 0 && p != '0 && tree_sib[p] != '0) begin
			p = tree_sib[p];
			hops--;
		end
		if (p == '0)
			return tcsl_pkg::KEY_W'($urandom);
		case ($urandom_range(0, 5))
			0: return tree_key[p] + 8'sd1;
			1: return tree_key[p] - 8'sd1;
			default: return tree_key[p];
		endcase
	endfunction

	// Result side stall: random stretches, with quiet spans of no stall at all.
	always @(posedge clk) begin
		if (stall_left != 0)
			stall_left--;
		else if (((cycles / 2000) % 3) != 2 && $urandom_range(0, 3) == 0)
			stall_left = gap_len();
		out_stall <= (stall_left != 0);
	end

	// Present one item, hold it until the transfer, then maybe go idle.
	task automatic push_item(input logic k, input logic [tcsl_pkg::IDX_W-1:0] idx,
			input logic signed [tcsl_pkg::KEY_W-1:0] ch,
			input logic [tcsl_pkg::IDX_W-1:0] sib,
			input logic [tcsl_pkg::IDX_W-1:0] chl,
			input logic [tcsl_pkg::VAL_W-1:0] val);
		int gap;
		in_valid <= 1'b1;
		kind <= k;
		node_index <= idx;
		key_char <= ch;
		sibling_link <= sib;
		child_link <= chl;
		payload_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (k == tcsl_pkg::KIND_LOAD) begin
			tree_key[idx] = ch;
			tree_sib[idx] = sib;
			tree_child[idx] = chl;
		end
		gap = in_calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic step_from(input logic [tcsl_pkg::IDX_W-1:0] idx,
			input logic signed [tcsl_pkg::KEY_W-1:0] ch);
		push_item(tcsl_pkg::KIND_STEP, idx, ch, tcsl_pkg::IDX_W'($urandom),
			tcsl_pkg::IDX_W'($urandom), $urandom);
	endtask

	// Wait until every step has been answered.
	task automatic wait_drained();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		int p;
		int f;
		int c;
		int k;
		int free;
		int n;
		int r;
		int tries;
		logic [tcsl_pkg::IDX_W-1:0] idx;
		logic [tcsl_pkg::IDX_W-1:0] lc;
		logic signed [tcsl_pkg::KEY_W-1:0] ch;

		in_valid <= 1'b0;
		kind <= tcsl_pkg::KIND_LOAD;
		node_index <= '0;
		key_char <= '0;
		sibling_link <= '0;
		child_link <= '0;
		payload_value <= '0;
		arst_n <= 1'b0;
		in_calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Plan a well-formed trie over every node: children get higher indexes and
		// ascending keys, so no walk can loop.
		for (int i = 0; i < tcsl_pkg::TABLE_MAX; i++) begin
			tree_key[i] = tcsl_pkg::KEY_W'($urandom);
			tree_sib[i] = '0;
			tree_child[i] = '0;
		end
		free = 2;
		for (p = 1; p < tcsl_pkg::TABLE_MAX && free < tcsl_pkg::TABLE_MAX; p++) begin
			f = (p == 1) ? $urandom_range(3, 6) : $urandom_range(0, 4);
			if (f > tcsl_pkg::TABLE_MAX - free)
				f = tcsl_pkg::TABLE_MAX - free;
			k = -128 + $urandom_range(0, 40);
			for (c = 0; c < f; c++) begin
				tree_key[free + c] = k[tcsl_pkg::KEY_W-1:0];
				k += $urandom_range(1, 40);
				tree_sib[free + c] = (c == f - 1) ? '0 : tcsl_pkg::IDX_W'(free + c + 1);
			end
			if (f > 0)
				tree_child[p] = tcsl_pkg::IDX_W'(free);
			free += f;
		end

		// Load every node, node zero included, so no walk reads an empty entry.
		for (int i = 0; i < tcsl_pkg::TABLE_MAX; i++)
			push_item(tcsl_pkg::KIND_LOAD, tcsl_pkg::IDX_W'(i), tree_key[i], tree_sib[i],
				tree_child[i], rand_word());

		// Directed: node zero, first and last child, misses on both ends and between.
		lc = tree_child[1];
		while (tree_sib[lc] != '0)
			lc = tree_sib[lc];
		step_from(8'd0, 8'sd0);
		step_from(8'd1, tree_key[tree_child[1]]);
		step_from(8'd1, tree_key[lc]);
		step_from(8'd1, -8'sd128);
		step_from(8'd1, 8'sd127);
		step_from(8'd1, tree_key[tree_child[1]] + 8'sd1);
		push_item(tcsl_pkg::KIND_STEP, 8'd1, tree_key[lc], '1, '1, '1);

		// Extreme keys and payloads, a leaf, and end of list.
		push_item(tcsl_pkg::KIND_LOAD, 8'd254, 8'sd127, 8'd0, 8'd255, '1);
		push_item(tcsl_pkg::KIND_LOAD, 8'd255, -8'sd128, 8'd0, 8'd0, '1);
		step_from(8'd254, -8'sd128);
		step_from(8'd254, 8'sd127);
		step_from(8'd255, 8'sd5);
		push_item(tcsl_pkg::KIND_LOAD, 8'd255, 8'sd127, 8'd0, 8'd0, '0);
		step_from(8'd254, -8'sd128);
		step_from(8'd254, 8'sd127);

		// Node zero may be loaded, but a step from it still gives nothing.
		push_item(tcsl_pkg::KIND_LOAD, 8'd0, -8'sd1, '1, 8'd255, '1);
		step_from(8'd0, 8'sd127);

		// A two-node sibling cycle: overlong walk, a hit, and a larger key.
		push_item(tcsl_pkg::KIND_LOAD, 8'd252, -8'sd5, 8'd253, 8'd0, 32'h1234_5678);
		push_item(tcsl_pkg::KIND_LOAD, 8'd253, -8'sd3, 8'd252, 8'd0, 32'h8765_4321);
		push_item(tcsl_pkg::KIND_LOAD, 8'd251, 8'sd0, 8'd0, 8'd252, 32'h0);
		step_from(8'd251, 8'sd127);
		step_from(8'd251, -8'sd3);
		step_from(8'd251, -8'sd4);

		// A node that is its own child and sibling.
		push_item(tcsl_pkg::KIND_LOAD, 8'd250, 8'sd0, 8'd250, 8'd250, 32'hcafe_f00d);
		step_from(8'd250, 8'sd1);
		step_from(8'd250, 8'sd0);

		// Random part: mostly steps aimed at real children, some payload reloads,
		// and a little noise in the links and keys.
		for (n = 0; n < ITEMS; n++) begin
			in_calm = ((n / 150) % 4) == 3;
			if (n == ITEMS / 2) begin
				in_valid <= 1'b0;
				wait_drained();
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				idx = tcsl_pkg::IDX_W'($urandom);
				if ($urandom_range(0, 4) != 0) begin
					tries = 0;
					while (tree_child[idx] == '0 && tries < 8) begin
						idx = tcsl_pkg::IDX_W'($urandom_range(1, tcsl_pkg::TABLE_MAX - 1));
						tries++;
					end
				end
				if ($urandom_range(0, 9) < 7)
					ch = pick_key(idx);
				else
					ch = tcsl_pkg::KEY_W'($urandom);
				step_from(idx, ch);
			end else if (r < 93) begin
				idx = tcsl_pkg::IDX_W'($urandom);
				push_item(tcsl_pkg::KIND_LOAD, idx, tree_key[idx], tree_sib[idx],
					tree_child[idx], rand_word());
			end else begin
				push_item(tcsl_pkg::KIND_LOAD, tcsl_pkg::IDX_W'($urandom),
					tcsl_pkg::KEY_W'($urandom), tcsl_pkg::IDX_W'($urandom),
					tcsl_pkg::IDX_W'($urandom), rand_word());
			end
		end
		in_valid <= 1'b0;

		// Let the block finish, then give the verdict.
		wait_drained();
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0)
			$display("[trie_child_step_lookup] OK");
		else
			$display("[trie_child_step_lookup] ERROR");
		$finish;
	end

endmodule
